@@ rtl/lbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH       = 3'd0,
        CMD_POP        = 3'd1,
        CMD_TOP        = 3'd2,
        CMD_POP_TOP    = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_PURGE      = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SCAN = 2'd2
    } t_state;

endpackage

`default_nettype wire

@@ rtl/bounded_lifo_stack_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO stack of 64 words of 32 bits, held in a single-port-write,
// single-port-read synchronous RAM (registered read data). One command is
// taken per transfer and gives exactly one result transfer, carrying status,
// the top word (top and pop_top), and empty/full/depth after the command.
// Push, pop, clear, underflow/overflow cases and unused codes finish in the
// cycle of the input transfer: the result is registered at that edge, so
// these run at one command per cycle as long as the result side keeps up.
// Top and pop_top issue the RAM read of the top entry at the command edge
// and register the result in the cycle after that. Purge (remove every copy
// of a word) compacts the stack in place by walking entries 0..depth-1
// through the RAM read port, one per cycle, writing survivors back at a
// trailing index; its result is registered once the walk has compared the
// last entry (in the cycle after the command on an empty stack), and no new
// command is accepted meanwhile. The input side is ready whenever no command
// is in flight and the result register is empty or being drained in the same
// cycle. No clearing pass is needed after reset: entries above the depth are
// never used.
module bounded_lifo_stack_engine_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // command channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [lbs_pkg::CMD_W-1:0]          i_command,
    input  wire logic [31:0]                        i_value,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [lbs_pkg::STAT_W-1:0]              o_status,
    output logic [31:0]                             o_read_value,
    output logic                                    o_is_empty,
    output logic                                    o_is_full,
    output logic [lbs_pkg::CNT_W-1:0]               o_depth_count
);

    localparam int AW = lbs_pkg::ADDR_W;
    localparam int CW = lbs_pkg::CNT_W;
    localparam int DW = lbs_pkg::DATA_WIDTH;
    localparam logic [CW-1:0] CAP = CW'(lbs_pkg::CAPACITY);

    // storage
    logic [DW-1:0] mem [lbs_pkg::CAPACITY];
    logic [DW-1:0] r_rd_data;

    // control
    lbs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic            r_pop_after;      // pop_top: drop the entry when the read returns
    logic [CW-1:0]   r_idx;            // scan read pointer
    logic [CW-1:0]   r_kept;           // scan write pointer
    logic            r_cmp_valid;      // r_rd_data holds the entry at r_idx - 1
    logic [DW-1:0]   r_match;          // word being deleted

    // result register
    logic                     r_out_valid;
    lbs_pkg::t_status         r_status;
    logic [31:0]              r_read_value;
    logic [CW-1:0]            r_depth;

    logic            out_free;
    logic            in_xfer;
    lbs_pkg::t_cmd   cmd;
    logic            scan_more;
    logic            scan_done;
    logic            keep_entry;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [DW-1:0]   wdata;
    logic [AW-1:0]   raddr;

    logic              load_out;
    lbs_pkg::t_status  n_status;
    logic [31:0]       n_read_value;
    logic              start_read;
    logic              start_scan;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == lbs_pkg::S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign cmd        = lbs_pkg::t_cmd'(i_command);

    assign scan_more  = (r_idx < r_fill);
    assign scan_done  = !scan_more && !r_cmp_valid;
    assign keep_entry = r_cmp_valid && (r_rd_data != r_match);

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbs_pkg::S_IDLE: begin
                if (start_read) begin
                    n_state = lbs_pkg::S_READ;
                end else if (start_scan) begin
                    n_state = lbs_pkg::S_SCAN;
                end
            end
            lbs_pkg::S_READ: begin
                if (out_free) begin
                    n_state = lbs_pkg::S_IDLE;
                end
            end
            lbs_pkg::S_SCAN: begin
                if (scan_done && out_free) begin
                    n_state = lbs_pkg::S_IDLE;
                end
            end
            default: n_state = lbs_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath control and result values
    // ---------------------------------------------------------------
    always_comb begin
        n_fill       = r_fill;
        we           = 1'b0;
        waddr        = r_fill[AW-1:0];
        wdata        = i_value[DW-1:0];
        raddr        = AW'(r_fill - CW'(1));   // top entry while idle / reading
        load_out     = 1'b0;
        n_status     = lbs_pkg::ST_OK;
        n_read_value = '0;
        start_read   = 1'b0;
        start_scan   = 1'b0;

        unique case (r_state)
            lbs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    unique case (cmd) inside
                        lbs_pkg::CMD_PUSH: begin
                            load_out = 1'b1;
                            if (r_fill == CAP) begin
                                n_status = lbs_pkg::ST_OVER;
                            end else begin
                                we     = 1'b1;
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        lbs_pkg::CMD_POP,
                        lbs_pkg::CMD_TOP,
                        lbs_pkg::CMD_POP_TOP: begin
                            if (r_fill == '0) begin
                                load_out = 1'b1;
                                n_status = lbs_pkg::ST_UNDER;
                            end else if (cmd == lbs_pkg::CMD_POP) begin
                                load_out = 1'b1;
                                n_fill   = r_fill - CW'(1);
                            end else begin
                                start_read = 1'b1;
                            end
                        end
                        lbs_pkg::CMD_CLEAR: begin
                            load_out = 1'b1;
                            n_fill   = '0;
                        end
                        lbs_pkg::CMD_PURGE: begin
                            start_scan = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;       // unused code: no-op
                        end
                    endcase
                end
            end
            lbs_pkg::S_READ: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    n_read_value = 32'(r_rd_data);
                    if (r_pop_after) begin
                        n_fill = r_fill - CW'(1);
                    end
                end
            end
            lbs_pkg::S_SCAN: begin
                // read ahead at r_idx, write survivor back at r_kept (<= r_idx)
                raddr = r_idx[AW-1:0];
                we    = keep_entry;
                waddr = r_kept[AW-1:0];
                wdata = r_rd_data;
                if (scan_done && out_free) begin
                    load_out = 1'b1;
                    n_fill   = r_kept;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // RAM
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbs_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_idx       <= '0;
            r_kept      <= '0;
            r_pop_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (start_read) begin
                r_pop_after <= (cmd == lbs_pkg::CMD_POP_TOP);
            end

            if (start_scan) begin
                r_idx       <= '0;
                r_kept      <= '0;
                r_cmp_valid <= 1'b0;
            end else if (r_state == lbs_pkg::S_SCAN) begin
                r_cmp_valid <= scan_more;
                if (scan_more) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (keep_entry) begin
                    r_kept <= r_kept + CW'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start_scan) begin
            r_match <= i_value[DW-1:0];
        end
        if (load_out) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
            r_depth      <= n_fill;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_depth_count = r_depth;
    assign o_is_empty    = (r_depth == '0);
    assign o_is_full     = (r_depth == CAP);

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP)
        else $error("fill count above capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbs_pkg::S_SCAN) |-> (r_kept <= r_idx) && (r_idx <= r_fill))
        else $error("compaction write pointer ahead of read pointer");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbs_pkg::S_READ) |-> (r_fill != '0))
        else $error("top read pending on empty stack");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == lbs_pkg::ST_OVER)) |-> o_is_full)
        else $error("overflow reported while not full");

    a_scan_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbs_pkg::S_SCAN) |-> !o_in_ready)
        else $error("command accepted during compaction");

endmodule

`default_nettype wire
